[hdl/ppc_pkg.sv]
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants of the program phase classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

    localparam int TID_W     = 3;   // thread id field
    localparam int ID_W      = 3;   // phase id field
    localparam int THR_W     = 22;  // distance threshold register
    localparam int CONF_W    = 4;   // confirm count register and run counter
    localparam int CFG_IDX_W = 1;
    localparam int NFIELDS   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 1'd1;

    localparam logic [THR_W-1:0]  THRESH_RST  = 22'd5000;
    localparam logic [CONF_W-1:0] CONFIRM_RST = 4'd4;

    // request to the shared distance unit
    typedef struct packed {
        logic start;
    } t_dist_req;

    // response from the shared distance unit
    typedef struct packed {
        logic done;
        logic differs;
    } t_dist_rsp;

endpackage

`default_nettype wire

[hdl/program_phase_classifier_core.sv]
// ----------------------------------------------------------------------------
// program_phase_classifier_core
// Per-thread program phase detector with a shared distance unit.
// A first interval is stored as the candidate and an unknown thread goes straight
// to its result; otherwise one distance check, plus one more per phase table entry
// searched; each check is 4 field steps of the distance unit.
// One item at a time; the next item is taken once the result is registered.
// Reset (synchronous, active low) clears all thread records and restores
// the registers; the phase table itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module program_phase_classifier_core #(
    parameter int THREADS     = 8,
    parameter int PHASES      = 8,
    parameter int COUNT_WIDTH = 20
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration
    input  wire                              i_cfg_we,
    input  wire [ppc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [ppc_pkg::THR_W-1:0]         i_cfg_data,
    // input channel
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire [ppc_pkg::TID_W-1:0]         i_thread_id,
    input  wire [COUNT_WIDTH-1:0]            i_int_count,
    input  wire [COUNT_WIDTH-1:0]            i_branch_count,
    input  wire [COUNT_WIDTH-1:0]            i_fp_count,
    input  wire [COUNT_WIDTH-1:0]            i_mem_count,
    // output channel
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic                             o_phase_valid,
    output logic [ppc_pkg::ID_W-1:0]         o_phase_id,
    output logic                             o_phase_changed,
    output logic                             o_phase_new,
    output logic                             o_table_full
);

    localparam int SIG_W    = ppc_pkg::NFIELDS * COUNT_WIDTH;
    localparam int TIDX_W   = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int PW       = (PHASES > 1) ? $clog2(PHASES) : 1;
    localparam int CNTW     = $clog2(PHASES + 1);
    localparam int PT_DEPTH = THREADS * PHASES;
    localparam int PT_AW    = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
    localparam int REC_W    = 1 + CNTW + PW + ppc_pkg::CONF_W + SIG_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_THR  = 4'd1;
    localparam logic [3:0] S_CWT  = 4'd2;
    localparam logic [3:0] S_PWT  = 4'd3;
    localparam logic [3:0] S_SWT  = 4'd4;
    localparam logic [3:0] S_FIN  = 4'd5;

    // configuration registers
    logic [ppc_pkg::THR_W-1:0]  r_thresh;
    logic [ppc_pkg::CONF_W-1:0] r_confirm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= ppc_pkg::THRESH_RST;
            r_confirm <= ppc_pkg::CONFIRM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ppc_pkg::REG_THRESH:  r_thresh  <= i_cfg_data;
                ppc_pkg::REG_CONFIRM: r_confirm <= i_cfg_data[ppc_pkg::CONF_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state and working copy of one thread record
    logic [3:0]                 r_state, n_state;
    logic [TIDX_W-1:0]          r_tid, n_tid;
    logic [SIG_W-1:0]           r_sig, n_sig;
    logic                       r_loaded, n_loaded;
    logic [CNTW-1:0]            r_count, n_count;
    logic [PW-1:0]              r_cur, n_cur;
    logic [ppc_pkg::CONF_W-1:0] r_run, n_run;
    logic [SIG_W-1:0]           r_cand, n_cand;
    logic [PW-1:0]              r_idx, n_idx;
    logic                       r_sel_cand, n_sel_cand;
    logic                       r_wr_rec, n_wr_rec;
    logic                       r_changed, n_changed;
    logic                       r_fresh, n_fresh;
    logic                       r_full, n_full;

    // output register
    logic                       r_out_valid;
    logic                       r_o_pv;
    logic [ppc_pkg::ID_W-1:0]   r_o_id;
    logic                       r_o_chg;
    logic                       r_o_new;
    logic                       r_o_full;

    // thread record memory with per-thread valid bits
    logic [REC_W-1:0]   r_rec_mem [THREADS];
    logic [REC_W-1:0]   r_rec_rd;
    logic [THREADS-1:0] r_thr_valid;
    logic [REC_W-1:0]   rec;
    logic               rec_loaded;
    logic [CNTW-1:0]    rec_count;
    logic [PW-1:0]      rec_cur;
    logic [ppc_pkg::CONF_W-1:0] rec_run;
    logic [SIG_W-1:0]   rec_cand;

    // phase table memory
    logic [SIG_W-1:0]   r_pt_mem [PT_DEPTH];
    logic [SIG_W-1:0]   r_pt_rd;
    logic               pt_re;
    logic [PW-1:0]      pt_ridx;
    logic               pt_we;
    logic [PW-1:0]      pt_widx;
    logic [SIG_W-1:0]   pt_wdata;
    logic [PT_AW-1:0]   pt_raddr;
    logic [PT_AW-1:0]   pt_waddr;

    // shared distance unit
    ppc_pkg::t_dist_req dist_req;
    ppc_pkg::t_dist_rsp dist_rsp;
    logic [SIG_W-1:0]   dist_a;

    logic [ppc_pkg::CONF_W-1:0] run1;
    logic                       confirmed;
    logic [CNTW-1:0]            idx_next;
    logic                       out_free;
    logic [PW+ppc_pkg::ID_W-1:0] cur_ext;

    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign rec = r_thr_valid[r_tid] ? r_rec_rd : '0;
    assign {rec_loaded, rec_count, rec_cur, rec_run, rec_cand} = rec;

    assign run1      = r_run + 4'd1;
    assign confirmed = (run1 >= r_confirm);
    assign idx_next  = CNTW'(r_idx) + CNTW'(1);
    assign dist_a    = r_sel_cand ? r_cand : r_pt_rd;
    assign cur_ext   = {{ppc_pkg::ID_W{1'b0}}, r_cur};

    assign pt_raddr = PT_AW'(r_tid) * PT_AW'(PHASES) + PT_AW'(pt_ridx);
    assign pt_waddr = PT_AW'(r_tid) * PT_AW'(PHASES) + PT_AW'(pt_widx);

    always_comb begin
        n_state    = r_state;
        n_tid      = r_tid;
        n_sig      = r_sig;
        n_loaded   = r_loaded;
        n_count    = r_count;
        n_cur      = r_cur;
        n_run      = r_run;
        n_cand     = r_cand;
        n_idx      = r_idx;
        n_sel_cand = r_sel_cand;
        n_wr_rec   = r_wr_rec;
        n_changed  = r_changed;
        n_fresh    = r_fresh;
        n_full     = r_full;
        dist_req.start = 1'b0;
        pt_re      = 1'b0;
        pt_ridx    = '0;
        pt_we      = 1'b0;
        pt_widx    = '0;
        pt_wdata   = r_sig;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_tid     = TIDX_W'(i_thread_id);
                    n_sig     = {i_mem_count, i_fp_count, i_branch_count, i_int_count};
                    n_changed = 1'b0;
                    n_fresh   = 1'b0;
                    n_full    = 1'b0;
                    if (int'(i_thread_id) >= THREADS) begin
                        n_wr_rec = 1'b0;
                        n_state  = S_FIN;
                    end else begin
                        n_wr_rec = 1'b1;
                        n_state  = S_THR;
                    end
                end
            end
            S_THR: begin
                n_loaded = rec_loaded;
                n_count  = rec_count;
                n_cur    = rec_cur;
                n_run    = rec_run;
                n_cand   = rec_cand;
                if (rec_count == '0) begin
                    if (!rec_loaded) begin
                        // first interval of the thread becomes the candidate
                        n_cand   = r_sig;
                        n_loaded = 1'b1;
                        n_state  = S_FIN;
                    end else begin
                        n_sel_cand     = 1'b1;
                        dist_req.start = 1'b1;
                        n_state        = S_CWT;
                    end
                end else begin
                    pt_re          = 1'b1;
                    pt_ridx        = rec_cur;
                    n_sel_cand     = 1'b0;
                    dist_req.start = 1'b1;
                    n_state        = S_PWT;
                end
            end
            S_CWT: begin
                if (dist_rsp.done) begin
                    n_state = S_FIN;
                    if (dist_rsp.differs) begin
                        n_run  = '0;
                        n_cand = r_sig;
                    end else if (confirmed) begin
                        // phase 0 takes the candidate signature
                        n_run     = '0;
                        pt_we     = 1'b1;
                        pt_widx   = '0;
                        pt_wdata  = r_cand;
                        n_count   = CNTW'(1);
                        n_cur     = '0;
                        n_fresh   = 1'b1;
                        n_changed = 1'b1;
                    end else begin
                        n_run = run1;
                    end
                end
            end
            S_PWT: begin
                if (dist_rsp.done) begin
                    if (!dist_rsp.differs) begin
                        n_run   = '0;
                        n_state = S_FIN;
                    end else if (!confirmed) begin
                        n_run   = run1;
                        n_state = S_FIN;
                    end else begin
                        // search the table from entry 0
                        n_run          = '0;
                        n_idx          = '0;
                        pt_re          = 1'b1;
                        pt_ridx        = '0;
                        dist_req.start = 1'b1;
                        n_state        = S_SWT;
                    end
                end
            end
            S_SWT: begin
                if (dist_rsp.done) begin
                    if (!dist_rsp.differs) begin
                        n_cur     = r_idx;
                        pt_we     = 1'b1;
                        pt_widx   = r_idx;
                        n_changed = (r_idx != r_cur);
                        n_state   = S_FIN;
                    end else if (idx_next < r_count) begin
                        n_idx          = r_idx + PW'(1);
                        pt_re          = 1'b1;
                        pt_ridx        = r_idx + PW'(1);
                        dist_req.start = 1'b1;
                    end else if (int'(r_count) < PHASES) begin
                        n_cur     = PW'(r_count);
                        pt_we     = 1'b1;
                        pt_widx   = PW'(r_count);
                        n_count   = r_count + CNTW'(1);
                        n_fresh   = 1'b1;
                        n_changed = 1'b1;
                        n_state   = S_FIN;
                    end else begin
                        n_full  = 1'b1;
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_rec    <= 1'b0;
            r_thr_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_rec <= n_wr_rec;
            if (r_state == S_FIN && r_wr_rec) begin
                r_thr_valid[r_tid] <= 1'b1;
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_tid      <= n_tid;
        r_sig      <= n_sig;
        r_loaded   <= n_loaded;
        r_count    <= n_count;
        r_cur      <= n_cur;
        r_run      <= n_run;
        r_cand     <= n_cand;
        r_idx      <= n_idx;
        r_sel_cand <= n_sel_cand;
        r_changed  <= n_changed;
        r_fresh    <= n_fresh;
        r_full     <= n_full;
        if (r_state == S_FIN && out_free) begin
            r_o_pv   <= r_wr_rec && (r_count != '0);
            r_o_id   <= r_wr_rec ? cur_ext[ppc_pkg::ID_W-1:0] : '0;
            r_o_chg  <= r_wr_rec && r_changed;
            r_o_new  <= r_wr_rec && r_fresh;
            r_o_full <= r_wr_rec && r_full;
        end
    end

    // thread record memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_rec_rd <= r_rec_mem[TIDX_W'(i_thread_id)];
        end
        if (r_state == S_FIN && r_wr_rec) begin
            r_rec_mem[r_tid] <= {r_loaded, r_count, r_cur, r_run, r_cand};
        end
    end

    // phase table memory
    always_ff @(posedge i_clk) begin
        if (pt_re) begin
            r_pt_rd <= r_pt_mem[pt_raddr];
        end
        if (pt_we) begin
            r_pt_mem[pt_waddr] <= pt_wdata;
        end
    end

    ppc_dist #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (dist_req),
        .i_a      (dist_a),
        .i_b      (r_sig),
        .i_thresh (r_thresh),
        .o_rsp    (dist_rsp)
    );

    assign o_out_valid     = r_out_valid;
    assign o_phase_valid   = r_o_pv;
    assign o_phase_id      = r_o_id;
    assign o_phase_changed = r_o_chg;
    assign o_phase_new     = r_o_new;
    assign o_table_full    = r_o_full;

endmodule

`default_nettype wire

[hdl/ppc_dist.sv]
// ----------------------------------------------------------------------------
// ppc_dist
// Shared Manhattan distance unit: one field per cycle, then a threshold compare.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_dist #(
    parameter int COUNT_WIDTH = 20
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  ppc_pkg::t_dist_req                           i_req,
    input  wire [ppc_pkg::NFIELDS*COUNT_WIDTH-1:0]       i_a,
    input  wire [ppc_pkg::NFIELDS*COUNT_WIDTH-1:0]       i_b,
    input  wire [ppc_pkg::THR_W-1:0]                     i_thresh,
    output ppc_pkg::t_dist_rsp                           o_rsp
);

    localparam int ACC_W = COUNT_WIDTH + 2;
    localparam int CMP_W = (ACC_W > ppc_pkg::THR_W) ? ACC_W : ppc_pkg::THR_W;

    logic             r_busy;
    logic             r_cmp;
    logic [1:0]       r_k;
    logic [ACC_W-1:0] r_acc;
    logic             r_done;
    logic             r_differs;

    logic [COUNT_WIDTH-1:0] fa;
    logic [COUNT_WIDTH-1:0] fb;
    logic [COUNT_WIDTH-1:0] absdiff;

    always_comb begin
        fa      = i_a[r_k*COUNT_WIDTH +: COUNT_WIDTH];
        fb      = i_b[r_k*COUNT_WIDTH +: COUNT_WIDTH];
        absdiff = (fa > fb) ? (fa - fb) : (fb - fa);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cmp     <= 1'b0;
            r_k       <= 2'd0;
            r_done    <= 1'b0;
            r_differs <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cmp  <= 1'b0;
                r_k    <= 2'd0;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= r_acc + ACC_W'(absdiff);
                r_k   <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_busy <= 1'b0;
                    r_cmp  <= 1'b1;
                end
            end else if (r_cmp) begin
                r_cmp     <= 1'b0;
                r_done    <= 1'b1;
                r_differs <= CMP_W'(r_acc) > CMP_W'(i_thresh);
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.differs = r_differs;

endmodule

`default_nettype wire

[hdl/ppc_checker.sv]
// ----------------------------------------------------------------------------
// ppc_checker
// Port-level checks of the phase classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      o_out_valid,
    input wire                      i_out_stall,
    input wire                      o_phase_valid,
    input wire [ppc_pkg::ID_W-1:0]  o_phase_id,
    input wire                      o_phase_changed,
    input wire                      o_phase_new,
    input wire                      o_table_full
);

    // a stalled item stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    // a stalled item keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_phase_id) && $stable(o_phase_valid)
            && $stable(o_phase_changed) && $stable(o_phase_new) && $stable(o_table_full))
        else $error("result payload changed while stalled");

    // an allocation always changes the phase and leaves a valid phase
    a_new_changes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_phase_new |-> o_phase_valid && o_phase_changed && !o_table_full)
        else $error("allocation without phase change");

    // a full table keeps the current phase
    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_table_full |-> o_phase_valid && !o_phase_changed && !o_phase_new)
        else $error("full table changed the phase");

endmodule

bind program_phase_classifier_core ppc_checker u_ppc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_phase_valid   (o_phase_valid),
    .o_phase_id      (o_phase_id),
    .o_phase_changed (o_phase_changed),
    .o_phase_new     (o_phase_new),
    .o_table_full    (o_table_full)
);

`default_nettype wire

[sim/tb_program_phase_classifier_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_program_phase_classifier_core
// Self-checking bench for the phase classifier: a queue-fed driver sends
// interval counts, a shadow classifier per thread predicts each phase
// result, and a monitor compares every result as it is taken.
// ----------------------------------------------------------------------------

module tb_program_phase_classifier_core;

    localparam int THREADS     = 8;
    localparam int PHASES      = 8;
    localparam int CW          = 20;
    localparam int CMAX        = (1 << CW) - 1;
    localparam int NBASE       = 11;     // more program behaviors than table entries
    localparam int STUCK_LIMIT = 4000;
    localparam int NPHASE      = 6;

    typedef logic [ppc_pkg::NFIELDS-1:0][CW-1:0] t_sig;   // int, branch, fp, mem

    typedef struct packed {
        logic [ppc_pkg::TID_W-1:0] tid;
        t_sig                      sig;
    } t_interval;

    typedef struct packed {
        logic                     valid;
        logic [ppc_pkg::ID_W-1:0] id;
        logic                     changed;
        logic                     fresh;
        logic                     full;
    } t_phase_res;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_cfg_we       = 1'b0;
    logic [ppc_pkg::CFG_IDX_W-1:0] i_cfg_index    = ppc_pkg::REG_THRESH;
    logic [ppc_pkg::THR_W-1:0]     i_cfg_data     = '0;
    logic                          i_in_valid     = 1'b0;
    logic [ppc_pkg::TID_W-1:0]     i_thread_id    = '0;
    logic [CW-1:0]                 i_int_count    = '0;
    logic [CW-1:0]                 i_branch_count = '0;
    logic [CW-1:0]                 i_fp_count     = '0;
    logic [CW-1:0]                 i_mem_count    = '0;
    logic                          i_out_stall    = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic                          o_phase_valid;
    logic [ppc_pkg::ID_W-1:0]      o_phase_id;
    logic                          o_phase_changed;
    logic                          o_phase_new;
    logic                          o_table_full;

    program_phase_classifier_core #(
        .THREADS     (THREADS),
        .PHASES      (PHASES),
        .COUNT_WIDTH (CW)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_thread_id     (i_thread_id),
        .i_int_count     (i_int_count),
        .i_branch_count  (i_branch_count),
        .i_fp_count      (i_fp_count),
        .i_mem_count     (i_mem_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_phase_valid   (o_phase_valid),
        .o_phase_id      (o_phase_id),
        .o_phase_changed (o_phase_changed),
        .o_phase_new     (o_phase_new),
        .o_table_full    (o_table_full)
    );

    always #10 i_clk = ~i_clk;

    // shadow classifier state
    t_sig        sig_store [THREADS][PHASES];
    int          n_phases  [THREADS] = '{default: 0};
    logic [2:0]  cur_phase [THREADS] = '{default: '0};
    logic [3:0]  run_cnt   [THREADS] = '{default: '0};
    t_sig        cand_sig  [THREADS] = '{default: '0};
    bit          cand_ok   [THREADS] = '{default: 1'b0};
    logic [21:0] thr_cfg  = ppc_pkg::THRESH_RST;
    logic [3:0]  conf_cfg = ppc_pkg::CONFIRM_RST;

    t_interval   interval_q [$];
    t_phase_res  phase_expect_q [$];
    t_interval   drv_item;
    bit          in_taken = 1'b0;
    int          in_idle_pct = 34;
    int          out_stall_pct = 34;
    int          n_queued = 0;
    int          n_accepted = 0;
    int          n_checked = 0;
    int          n_err = 0;
    int          stuck = 0;
    bit          moved;
    t_phase_res  got, want;

    // program behaviors each thread moves between
    t_sig        bases    [THREADS][NBASE];
    int          cur_base [THREADS] = '{default: 0};

    int ph_thr   [NPHASE] = '{5000, 0, 4194303, 20000, 1000, 5000};
    int ph_conf  [NPHASE] = '{4, 1, 15, 0, 2, 3};
    int ph_items [NPHASE] = '{150, 100, 60, 100, 150, 90};
    int ph_top   [NPHASE] = '{7, 1, 7, 3, 2, 7};
    int ph_idle  [NPHASE] = '{34, 34, 0, 34, 34, 34};

    function automatic logic [23:0] sig_distance(t_sig a, t_sig b);
        logic [23:0] sum;
        sum = '0;
        for (int k = 0; k < ppc_pkg::NFIELDS; k++) begin
            if (a[k] > b[k]) begin
                sum += a[k] - b[k];
            end else begin
                sum += b[k] - a[k];
            end
        end
        return sum;
    endfunction

    function automatic bit is_far(t_sig a, t_sig b);
        return sig_distance(a, b) > {2'b00, thr_cfg};
    endfunction

    // one more qualifying interval; true once the run is confirmed
    function automatic bit run_done(int t);
        run_cnt[t] = run_cnt[t] + 4'd1;
        if (run_cnt[t] >= conf_cfg) begin
            run_cnt[t] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_phase_res classify_interval(t_interval it);
        int         t, n, hit_idx;
        logic [2:0] old;
        bit         hit;
        t_phase_res r;
        t = int'(it.tid);
        r = '0;
        hit = 1'b0;
        hit_idx = 0;
        old = cur_phase[t];
        if (n_phases[t] == 0) begin
            if (!cand_ok[t]) begin
                cand_sig[t] = it.sig;
                cand_ok[t] = 1'b1;
            end else if (is_far(cand_sig[t], it.sig)) begin
                run_cnt[t] = '0;
                cand_sig[t] = it.sig;
            end else if (run_done(t)) begin
                // phase 0 is built from the candidate, not this interval
                sig_store[t][0] = cand_sig[t];
                n_phases[t] = 1;
                cur_phase[t] = '0;
                r.fresh = 1'b1;
                r.changed = 1'b1;
            end
        end else begin
            if (!is_far(sig_store[t][cur_phase[t]], it.sig)) begin
                run_cnt[t] = '0;
            end else if (run_done(t)) begin
                n = n_phases[t];
                for (int i = 0; i < n; i++) begin
                    if (!hit && !is_far(sig_store[t][i], it.sig)) begin
                        hit = 1'b1;
                        hit_idx = i;
                    end
                end
                if (hit) begin
                    cur_phase[t] = hit_idx[2:0];
                    sig_store[t][hit_idx] = it.sig;
                end else if (n < PHASES) begin
                    cur_phase[t] = n[2:0];
                    sig_store[t][n] = it.sig;
                    n_phases[t] = n + 1;
                    r.fresh = 1'b1;
                end else begin
                    r.full = 1'b1;
                end
                r.changed = (cur_phase[t] != old);
            end
        end
        r.valid = (n_phases[t] != 0);
        r.id = cur_phase[t];
        return r;
    endfunction

    function automatic t_sig mk_sig(int a, int b, int c, int d);
        t_sig s;
        s[0] = a[CW-1:0];
        s[1] = b[CW-1:0];
        s[2] = c[CW-1:0];
        s[3] = d[CW-1:0];
        return s;
    endfunction

    task automatic queue_interval(int t, t_sig s);
        t_interval it;
        it.tid = t[ppc_pkg::TID_W-1:0];
        it.sig = s;
        interval_q.push_back(it);
        n_queued++;
    endtask

    task automatic write_reg(logic [ppc_pkg::CFG_IDX_W-1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[ppc_pkg::THR_W-1:0];
        if (idx == ppc_pkg::REG_THRESH) begin
            thr_cfg = value[21:0];
        end else begin
            conf_cfg = value[3:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || phase_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // runs on a few program behaviors per thread, with some noise mixed in
    task automatic queue_random(int count, int thr_top);
        int   t, jit, v, sel;
        t_sig s;
        for (int k = 0; k < count; k++) begin
            t = $urandom_range(thr_top);
            if ($urandom_range(99) < 15) begin
                cur_base[t] = $urandom_range(NBASE - 1);
            end
            jit = int'(thr_cfg) / 8;
            if ($urandom_range(99) < 8) begin
                for (int f = 0; f < ppc_pkg::NFIELDS; f++) begin
                    sel = $urandom_range(9);
                    if (sel == 0) begin
                        s[f] = '0;
                    end else if (sel == 1) begin
                        s[f] = CMAX[CW-1:0];
                    end else begin
                        s[f] = CW'($urandom_range(CMAX));
                    end
                end
            end else begin
                for (int f = 0; f < ppc_pkg::NFIELDS; f++) begin
                    v = int'(bases[t][cur_base[t]][f]) + int'($urandom_range(2 * jit)) - jit;
                    if (v < 0) begin
                        v = 0;
                    end
                    if (v > CMAX) begin
                        v = CMAX;
                    end
                    s[f] = v[CW-1:0];
                end
            end
            queue_interval(t, s);
        end
    endtask

    // driver: next item goes out at the falling edge once the last one was taken
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (interval_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
                drv_item = interval_q.pop_front();
                i_in_valid <= 1'b1;
                i_thread_id <= drv_item.tid;
                i_int_count <= drv_item.sig[0];
                i_branch_count <= drv_item.sig[1];
                i_fp_count <= drv_item.sig[2];
                i_mem_count <= drv_item.sig[3];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // monitor: results checked first, then the item taken at this edge is predicted
    always @(posedge i_clk) begin
        moved = 1'b0;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            moved = 1'b1;
            got = '{o_phase_valid, o_phase_id, o_phase_changed, o_phase_new, o_table_full};
            if (phase_expect_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) begin
                    $display("unexpected phase result: v=%0b id=%0d chg=%0b new=%0b full=%0b",
                             got.valid, got.id, got.changed, got.fresh, got.full);
                end
            end else begin
                want = phase_expect_q.pop_front();
                if (got !== want) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("result %0d: expected v=%0b id=%0d chg=%0b new=%0b full=%0b",
                                 n_checked, want.valid, want.id, want.changed, want.fresh,
                                 want.full);
                        $display("result %0d: actual   v=%0b id=%0d chg=%0b new=%0b full=%0b",
                                 n_checked, got.valid, got.id, got.changed, got.fresh,
                                 got.full);
                    end
                end
            end
            n_checked++;
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            moved = 1'b1;
            phase_expect_q.push_back(classify_interval(drv_item));
            in_taken = 1'b1;
            n_accepted++;
        end
        if (moved) begin
            stuck = 0;
        end else if (interval_q.size() > 0 || i_in_valid || phase_expect_q.size() > 0) begin
            stuck++;
            if (stuck >= STUCK_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        for (int t = 0; t < THREADS; t++) begin
            for (int b = 0; b < NBASE; b++) begin
                for (int f = 0; f < ppc_pkg::NFIELDS; f++) begin
                    bases[t][b][f] = CW'($urandom_range(CMAX));
                end
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: candidate load, candidate replace, first allocation
        queue_interval(0, mk_sig(100000, 20000, 0, 30000));
        queue_interval(0, mk_sig(50000, 10000, 40000, 25000));
        queue_interval(0, mk_sig(50000, 10000, 40000, 25000));
        queue_interval(0, mk_sig(51000, 10000, 40000, 25000));
        queue_interval(0, mk_sig(50000, 9000, 40000, 25000));
        queue_interval(0, mk_sig(50000, 10000, 41000, 25000));
        // similar after a phase exists clears the run
        queue_interval(0, mk_sig(50000, 10000, 40000, 26000));
        // distant run allocates phase 1, then a run back matches phase 0
        for (int k = 0; k < 4; k++) begin
            queue_interval(0, mk_sig(0, 0, 200000, 90000 + k));
        end
        for (int k = 0; k < 4; k++) begin
            queue_interval(0, mk_sig(50000 + k, 10000, 40000, 25000));
        end
        // distance right at the threshold is similar, one above differs
        queue_interval(2, mk_sig(300000, 300000, 300000, 300000));
        queue_interval(2, mk_sig(305000, 300000, 300000, 300000));
        queue_interval(2, mk_sig(300000, 300000, 300000, 305001));
        // field extremes
        queue_interval(1, mk_sig(0, 0, 0, 0));
        queue_interval(1, mk_sig(CMAX, CMAX, CMAX, CMAX));
        queue_interval(7, mk_sig(CMAX, CMAX, CMAX, CMAX));
        wait_drained();

        for (int p = 0; p < NPHASE; p++) begin
            write_reg(ppc_pkg::REG_THRESH, ph_thr[p]);
            write_reg(ppc_pkg::REG_CONFIRM, ph_conf[p]);
            in_idle_pct = ph_idle[p];
            out_stall_pct = ph_idle[p];
            queue_random(ph_items[p], ph_top[p]);
            wait_drained();
        end

        repeat (64) @(negedge i_clk);
        if (phase_expect_q.size() != 0) begin
            n_err++;
        end
        if (n_err == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
